/* rtl/core/cfb_pkg.sv */
// cfb_pkg: shared types and constants of the command frame builder
// no dependencies; imported by every module under rtl/core
package cfb_pkg;

    localparam int unsigned MAX_COMMAND_BYTES_DEF = 254;

    localparam logic [7:0] PREAMBLE_BYTE   = 8'h00;
    localparam logic [7:0] START_CODE_BYTE = 8'hFF;
    localparam logic [7:0] POSTAMBLE_BYTE  = 8'h00;

    localparam logic [7:0] BUS_ADDR_RESET  = 8'h48;
    localparam logic [7:0] FRAME_ID_RESET  = 8'hD4;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BUS_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_ID = 2'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] frame_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_frame;
    } t_out_item;

    // one accepted request with everything needed to emit its bytes
    typedef struct packed {
        logic       first;
        logic       last;
        logic [7:0] data_byte;
        logic [7:0] len_field;
        logic [7:0] bus_addr;
        logic [7:0] frame_id;
        logic [7:0] dcs;
    } t_seq_item;

    typedef struct packed {
        logic [7:0] bus_addr;
        logic [7:0] frame_id;
    } t_cfg;

    typedef enum logic [3:0] {
        PH_ADDR,
        PH_PRE0,
        PH_PRE1,
        PH_START,
        PH_LEN,
        PH_LCS,
        PH_FID,
        PH_DATA,
        PH_DCS,
        PH_POST
    } t_phase;

endpackage

/* rtl/core/cfb_cfg_regs.sv */
// cfb_cfg_regs: bus address and frame identifier registers
// depends on cfb_pkg
module cfb_cfg_regs
    import cfb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bus_addr <= BUS_ADDR_RESET;
            r_cfg.frame_id <= FRAME_ID_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IDX_BUS_ADDR: r_cfg.bus_addr <= i_cfg_wdata;
                CFG_IDX_FRAME_ID: r_cfg.frame_id <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/cfb_sequencer.sv */
// cfb_sequencer: request register, frame bookkeeping and byte sequencing
// depends on cfb_pkg
module cfb_sequencer
    import cfb_pkg::*;
#(
    parameter int unsigned MAX_COMMAND_BYTES = MAX_COMMAND_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_space,
    output logic      o_emit,
    output t_out_item o_emit_item
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_COMMAND_BYTES);

    logic       r_busy;
    t_phase     r_phase;
    t_seq_item  r_item;
    logic       r_in_frame;
    logic [7:0] r_bytes_left;
    logic [7:0] r_sum;

    logic       n_busy;
    t_phase     n_phase;
    logic       accept;
    logic       fire;
    logic       final_byte;
    logic [7:0] len;
    logic [7:0] sum_base;
    logic [7:0] sum_new;
    logic [7:0] left_base;
    logic [7:0] left_new;
    t_seq_item  n_item;

    assign fire       = r_busy && i_out_space;
    assign final_byte = r_item.last ? (r_phase == PH_POST) : (r_phase == PH_DATA);
    assign o_in_stall = r_busy && !(fire && final_byte);
    assign accept     = i_in_valid && !o_in_stall;

    // frame bookkeeping of the incoming request
    always_comb begin
        if (i_in_item.frame_length == 8'd0) begin
            len = 8'd1;
        end else if (i_in_item.frame_length > MAX_LEN) begin
            len = MAX_LEN;
        end else begin
            len = i_in_item.frame_length;
        end
        sum_base  = r_in_frame ? r_sum : i_cfg.frame_id;
        sum_new   = sum_base + i_in_item.data_byte;
        left_base = r_in_frame ? r_bytes_left : len;
        left_new  = left_base - 8'd1;

        n_item.first     = !r_in_frame;
        n_item.last      = (left_new == 8'd0);
        n_item.data_byte = i_in_item.data_byte;
        n_item.len_field = len + 8'd1;
        n_item.bus_addr  = i_cfg.bus_addr;
        n_item.frame_id  = i_cfg.frame_id;
        n_item.dcs       = 8'd0 - sum_new;
    end

    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        if (fire) begin
            unique case (r_phase)
                PH_ADDR:  n_phase = PH_PRE0;
                PH_PRE0:  n_phase = PH_PRE1;
                PH_PRE1:  n_phase = PH_START;
                PH_START: n_phase = PH_LEN;
                PH_LEN:   n_phase = PH_LCS;
                PH_LCS:   n_phase = PH_FID;
                PH_FID:   n_phase = PH_DATA;
                PH_DATA:  n_phase = PH_DCS;
                PH_DCS:   n_phase = PH_POST;
                PH_POST:  n_phase = PH_ADDR;
                default:  n_phase = PH_ADDR;
            endcase
            if (final_byte) begin
                n_busy = 1'b0;
            end
        end
        if (accept) begin
            n_busy  = 1'b1;
            n_phase = r_in_frame ? PH_DATA : PH_ADDR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_phase      <= PH_ADDR;
            r_in_frame   <= 1'b0;
            r_bytes_left <= 8'd0;
            r_sum        <= 8'd0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
            if (accept) begin
                r_in_frame   <= !n_item.last;
                r_bytes_left <= left_new;
                r_sum        <= n_item.last ? 8'd0 : sum_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    always_comb begin
        o_emit_item.last_of_frame = 1'b0;
        unique case (r_phase)
            PH_ADDR:  o_emit_item.out_byte = r_item.bus_addr;
            PH_PRE0:  o_emit_item.out_byte = PREAMBLE_BYTE;
            PH_PRE1:  o_emit_item.out_byte = PREAMBLE_BYTE;
            PH_START: o_emit_item.out_byte = START_CODE_BYTE;
            PH_LEN:   o_emit_item.out_byte = r_item.len_field;
            PH_LCS:   o_emit_item.out_byte = 8'd0 - r_item.len_field;
            PH_FID:   o_emit_item.out_byte = r_item.frame_id;
            PH_DATA:  o_emit_item.out_byte = r_item.data_byte;
            PH_DCS:   o_emit_item.out_byte = r_item.dcs;
            PH_POST: begin
                o_emit_item.out_byte      = POSTAMBLE_BYTE;
                o_emit_item.last_of_frame = 1'b1;
            end
            default:  o_emit_item.out_byte = r_item.data_byte;
        endcase
    end

    assign o_emit = fire;

endmodule

/* rtl/core/cfb_out_buf.sv */
// cfb_out_buf: two-entry output buffer so the request side sees a registered space flag
// depends on cfb_pkg
module cfb_out_buf
    import cfb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_item,
    output logic      o_space,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_out_item  r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_space     = (r_count != 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign o_out_item  = r_mem[r_rptr];
    assign pop         = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

/* rtl/core/command_frame_builder_unit.sv */
// command_frame_builder_unit: top level of the command frame builder
// depends on cfb_pkg, cfb_cfg_regs, cfb_sequencer, cfb_out_buf
//
// Input channel (i_in_valid / o_in_stall / i_in_item) takes the command bytes
// of a frame one request at a time; frame_length is read on the first byte only.
// Output channel (o_out_valid / i_out_stall / o_out_item) gives the framed byte
// stream one byte per cycle while i_out_stall is low: bus address, preamble,
// start code, LEN, LCS, frame identifier, the command bytes, then DCS and the
// postamble with last_of_frame. The byte sequencer emits one byte per cycle
// while the output buffer has space; a request produces 1 byte for a middle
// byte, 8 for a first byte, 3 for a last byte, 10 for a one-byte frame. A new
// request is taken in the cycle its predecessor emits its final byte, so command
// bytes stream at one per cycle while the output buffer has space.
// A two-entry output buffer holds bytes while the receiver stalls; the request
// side stalls once it is full. Synchronous reset empties the buffer, ends any
// open frame and restores the bus address (0x48) and frame identifier (0xD4).
// Configuration writes (i_cfg_we) take effect at the next edge, no read-back;
// unknown indexes are ignored.
module command_frame_builder_unit
    import cfb_pkg::*;
#(
    parameter int unsigned MAX_COMMAND_BYTES = MAX_COMMAND_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item
);

    t_cfg      cfg;
    logic      out_space;
    logic      emit;
    t_out_item emit_item;

    cfb_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    cfb_sequencer #(
        .MAX_COMMAND_BYTES (MAX_COMMAND_BYTES)
    ) u_sequencer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_out_space (out_space),
        .o_emit      (emit),
        .o_emit_item (emit_item)
    );

    cfb_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (emit),
        .i_item      (emit_item),
        .o_space     (out_space),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
